>>> hw/rtl/mtg_pkg.sv
// Shared constants, types and the tempering function for the MT19937 generator.
// No dependencies; used by every module of the block.
package mtg_pkg;

    localparam int unsigned MT_N    = 624;
    localparam int unsigned MT_M    = 397;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned ADDR_W  = $clog2(MT_N);
    localparam int unsigned BOUND_W = 31;
    localparam int unsigned FUNC_W  = 2;

    localparam logic [WORD_W-1:0] INIT_MULT    = 32'h6c07_8965;
    localparam logic [WORD_W-1:0] MATRIX_A     = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RESEED = 2'd0,
        FUNC_RAW    = 2'd1,
        FUNC_HALF   = 2'd2,
        FUNC_MOD    = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_REGEN_PRE,
        ST_REGEN_RD1,
        ST_REGEN_RD2,
        ST_REGEN_WR,
        ST_DRAW_RD,
        ST_DRAW_DATA,
        ST_MOD_DIV
    } state_t;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

>>> hw/rtl/mtg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on mtg_pkg for default sizes.
module mtg_ram #(
    parameter int unsigned WIDTH = mtg_pkg::WORD_W,
    parameter int unsigned DEPTH = mtg_pkg::MT_N
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/mtg_rem_unit.sv
// Bit-serial restoring remainder unit: 32-bit dividend by 31-bit nonzero divisor.
// One quotient bit per cycle; depends on mtg_pkg for widths.
module mtg_rem_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mtg_pkg::WORD_W-1:0]  dividend,
    input  logic [mtg_pkg::BOUND_W-1:0] divisor,
    output logic                        done,
    output logic [mtg_pkg::BOUND_W-1:0] rem
);
    import mtg_pkg::*;

    localparam int unsigned CNT_W = $clog2(WORD_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [WORD_W-1:0]  dvd_reg, dvd_next;
    logic [BOUND_W-1:0] rem_reg, rem_next;
    logic [BOUND_W-1:0] div_reg, div_next;
    logic [WORD_W-1:0]  trial;
    logic [WORD_W-1:0]  diff;

    // partial remainder stays below the divisor, so the shifted trial fits 32 bits
    assign trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (busy_reg)
        begin
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[BOUND_W-1:0];
            end
            else
            begin
                rem_next = trial[BOUND_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WORD_W - 1);
            dvd_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

>>> hw/rtl/mersenne_twister_generator.sv
// Top level of the MT19937 generator: control sequencer around the state RAM.
// Depends on mtg_pkg, mtg_ram and mtg_rem_unit.
//
// Usage:
//   A command beat is taken when start is high and busy is low; func selects
//   reseed (0), raw draw (1), draw shifted right by one (2) or draw modulo
//   bound (3). Each command gives exactly one result beat: done is high for one
//   cycle with value and bad_bound valid. The receiver cannot stall; done is
//   never held off.
//   seed_we writes seed_value into the seed register at any idle edge.
// Sequence from the accepting edge to done:
//   draw, position below 624 : the single RAM read port, then tempering
//   modulo draw              : a draw, then the remainder unit (one remainder bit per cycle)
//   modulo with bound zero   : done with nothing consumed, bad_bound set
//   reseed                   : multiply then add per state word
//   every 624th draw first runs the twist (two reads, one write per word)
//   a draw before any seeding first seeds with 4357, then runs the twist.
//   busy falls in the cycle done rises, so the next command can follow then.
// Reset clears control state and the seed register; the state RAM needs no
// clearing as it is always seeded before it is read.
module mersenne_twister_generator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mtg_pkg::FUNC_W-1:0]   func,
    input  logic [mtg_pkg::BOUND_W-1:0]  bound,
    input  logic                         seed_we,
    input  logic signed [mtg_pkg::WORD_W-1:0] seed_value,
    output logic                         done,
    output logic [mtg_pkg::WORD_W-1:0]   value,
    output logic                         bad_bound
);
    import mtg_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(MT_N - 1);
    localparam logic [ADDR_W-1:0] WRAP_IDX = ADDR_W'(MT_N - MT_M);
    localparam logic [ADDR_W-1:0] M_OFF    = ADDR_W'(MT_M);
    localparam logic [ADDR_W-1:0] N_POS    = ADDR_W'(MT_N);

    state_t              state_reg, state_next;
    logic [WORD_W-1:0]   seed_reg;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic                seeded_reg, seeded_next;
    func_t               op_reg, op_next;
    logic [BOUND_W-1:0]  bound_reg, bound_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [WORD_W-1:0]   last_reg, last_next;
    logic [WORD_W-1:0]   nxt_reg, nxt_next;
    logic [WORD_W-1:0]   prod_reg, prod_next;
    logic                done_reg, done_next;
    logic [WORD_W-1:0]   value_reg, value_next;
    logic                bad_reg, bad_next;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [WORD_W-1:0]   mem_rdata;

    logic                div_start;
    logic                div_done;
    logic [BOUND_W-1:0]  div_rem;

    logic                accept;
    func_t               func_in;
    logic [2*WORD_W-1:0] mult_full;
    logic [WORD_W-1:0]   seed_word;
    logic [WORD_W-1:0]   twist_y;
    logic [WORD_W-1:0]   twist_w;
    logic [WORD_W-1:0]   tempered;

    assign accept    = start && (state_reg == ST_IDLE);
    assign func_in   = func_t'(func);
    assign mult_full = INIT_MULT * (last_reg ^ (last_reg >> 30));
    assign seed_word = prod_reg + {{(WORD_W - ADDR_W){1'b0}}, idx_reg};
    assign twist_y   = {last_reg[WORD_W-1], nxt_reg[WORD_W-2:0]};
    assign twist_w   = mem_rdata ^ (twist_y >> 1) ^ (twist_y[0] ? MATRIX_A : '0);
    assign tempered  = temper(mem_rdata);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func_in == FUNC_RESEED || !seeded_reg)
                    begin
                        if (!(func_in == FUNC_MOD && bound == '0))
                        begin
                            state_next = ST_SEED_MUL;
                        end
                    end
                    else if (func_in == FUNC_MOD && bound == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (pos_reg == N_POS)
                    begin
                        state_next = ST_REGEN_PRE;
                    end
                    else
                    begin
                        state_next = ST_DRAW_RD;
                    end
                end
            end
            ST_SEED_MUL:
            begin
                state_next = ST_SEED_ADD;
            end
            ST_SEED_ADD:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = (op_reg == FUNC_RESEED) ? ST_IDLE : ST_REGEN_PRE;
                end
                else
                begin
                    state_next = ST_SEED_MUL;
                end
            end
            ST_REGEN_PRE:
            begin
                state_next = ST_REGEN_RD1;
            end
            ST_REGEN_RD1:
            begin
                state_next = ST_REGEN_RD2;
            end
            ST_REGEN_RD2:
            begin
                state_next = ST_REGEN_WR;
            end
            ST_REGEN_WR:
            begin
                state_next = (idx_reg == LAST_IDX) ? ST_DRAW_RD : ST_REGEN_RD1;
            end
            ST_DRAW_RD:
            begin
                state_next = ST_DRAW_DATA;
            end
            ST_DRAW_DATA:
            begin
                state_next = (op_reg == FUNC_MOD) ? ST_MOD_DIV : ST_IDLE;
            end
            ST_MOD_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pos_next    = pos_reg;
        seeded_next = seeded_reg;
        op_next     = op_reg;
        bound_next  = bound_reg;
        idx_next    = idx_reg;
        last_next   = last_reg;
        nxt_next    = nxt_reg;
        prod_next   = prod_reg;
        done_next   = 1'b0;
        value_next  = '0;
        bad_next    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = seed_word;
        mem_raddr   = '0;
        div_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = func_in;
                    bound_next = bound;
                    if (func_in == FUNC_MOD && bound == '0)
                    begin
                        done_next = 1'b1;
                        bad_next  = 1'b1;
                    end
                    else if (func_in == FUNC_RESEED || !seeded_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = (func_in == FUNC_RESEED) ? seed_reg : DEFAULT_SEED;
                        last_next = mem_wdata;
                        idx_next  = ADDR_W'(1);
                    end
                end
            end
            ST_SEED_MUL:
            begin
                prod_next = mult_full[WORD_W-1:0];
            end
            ST_SEED_ADD:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = seed_word;
                last_next = seed_word;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    pos_next    = N_POS;
                    seeded_next = 1'b1;
                    if (op_reg == FUNC_RESEED)
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ST_REGEN_PRE:
            begin
                mem_raddr = '0;
                idx_next  = '0;
            end
            ST_REGEN_RD1:
            begin
                // word k+1; the first pass also picks up word 0 from the preload read
                mem_raddr = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                if (idx_reg == '0)
                begin
                    last_next = mem_rdata;
                end
            end
            ST_REGEN_RD2:
            begin
                mem_raddr = (idx_reg < WRAP_IDX) ? idx_reg + M_OFF : idx_reg - WRAP_IDX;
                nxt_next  = mem_rdata;
            end
            ST_REGEN_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = twist_w;
                last_next = nxt_reg;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    pos_next = '0;
                end
            end
            ST_DRAW_RD:
            begin
                mem_raddr = pos_reg;
                pos_next  = pos_reg + 1'b1;
            end
            ST_DRAW_DATA:
            begin
                case (op_reg)
                    FUNC_RAW:
                    begin
                        done_next  = 1'b1;
                        value_next = tempered;
                    end
                    FUNC_HALF:
                    begin
                        done_next  = 1'b1;
                        value_next = tempered >> 1;
                    end
                    FUNC_MOD:
                    begin
                        div_start = 1'b1;
                    end
                    default:
                    begin
                        done_next = 1'b0;
                    end
                endcase
            end
            ST_MOD_DIV:
            begin
                if (div_done)
                begin
                    done_next  = 1'b1;
                    value_next = {1'b0, div_rem};
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            seed_reg   <= '0;
            pos_reg    <= '0;
            seeded_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            seeded_reg <= seeded_next;
            done_reg   <= done_next;
            if (seed_we)
            begin
                seed_reg <= $unsigned(seed_value);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        bound_reg <= bound_next;
        idx_reg   <= idx_next;
        last_reg  <= last_next;
        nxt_reg   <= nxt_next;
        prod_reg  <= prod_next;
        value_reg <= value_next;
        bad_reg   <= bad_next;
    end

    mtg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MT_N)
    ) u_state_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mtg_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tempered),
        .divisor  (bound_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign value     = value_reg;
    assign bad_bound = bad_reg;

    a_bad_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && bad_reg) |-> (value_reg == '0))
        else $error("rejected modulo beat carries a nonzero value");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= N_POS)
        else $error("position beyond state size");

    a_draw_needs_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW_RD) |-> (seeded_reg && pos_reg < N_POS))
        else $error("draw read from unseeded or exhausted state");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD_DIV) |-> (bound_reg != '0))
        else $error("remainder unit running with zero divisor");

    a_seeded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(seeded_reg))
        else $error("seeded flag dropped");

endmodule
